>>> rtl/tlc_pkg.sv
`timescale 1ns / 1ps
// Package for the two-level LRU write-back cache tag model.
// Holds register indexes and the state machine encoding; no dependencies.
package tlc_pkg;
	localparam int unsigned RegOffsetBits = 0;
	localparam int unsigned RegL1SetBits  = 1;
	localparam int unsigned RegL1Ways     = 2;
	localparam int unsigned RegL2SetBits  = 3;
	localparam int unsigned RegL2Ways     = 4;

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_L1RD  = 7'b0000010,
		ST_L1EV  = 7'b0000100,
		ST_L2RD  = 7'b0001000,
		ST_L2UPD = 7'b0010000,
		ST_L1FIL = 7'b0100000,
		ST_DONE  = 7'b1000000
	} state_t;
endpackage

>>> rtl/tlc_set_array.sv
`timescale 1ns / 1ps
// One tag array: a synchronous memory holding a whole set (tags, valid, dirty,
// LRU ranks) per row, with a registered read port. Depends on nothing else.
module tlc_set_array #(
	parameter int unsigned SETS = 64,
	parameter int unsigned WAYS = 4,
	parameter int unsigned TAG_W = 26
) (
	input  logic clk,
	input  logic rd_en,
	input  logic [(SETS > 1 ? $clog2(SETS) : 1)-1:0] rd_addr,
	output logic [WAYS*(TAG_W+2+(WAYS > 1 ? $clog2(WAYS) : 1))-1:0] rd_data,
	input  logic wr_en,
	input  logic [(SETS > 1 ? $clog2(SETS) : 1)-1:0] wr_addr,
	input  logic [WAYS*(TAG_W+2+(WAYS > 1 ? $clog2(WAYS) : 1))-1:0] wr_data
);
	localparam int unsigned RowW = WAYS*(TAG_W+2+(WAYS > 1 ? $clog2(WAYS) : 1));
	logic [RowW-1:0] mem_q [SETS];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end
endmodule

>>> rtl/two_level_lru_writeback_cache_top.sv
`timescale 1ns / 1ps
// Top level of the two-level LRU write-back cache tag model.
// Uses tlc_pkg and two tlc_set_array memories (L1 and L2).
//
//  channel   | handshake          | payload
//  access    | start / busy       | mode, address
//  result    | done (one cycle)   | l1_hit, l1_victim_wb, l2_write_hit,
//            |                    | l2_read_hit, memory_writebacks
//  config    | APB write/read     | paddr, pwdata, prdata
//
// An access goes ST_L1RD, ST_L1EV, ST_DONE on a hit and ST_L1RD, ST_L1EV, ST_L2RD,
// ST_L2UPD, ST_L1FIL, ST_DONE on a miss, with ST_L2RD/ST_L2UPD run twice, the writeback
// first, for a dirty victim: one read-modify-write pass on a set memory per visit.
// A new transaction is taken in the cycle after done. After reset, a clearing pass of all
// sets runs with busy high. The receiver cannot stall; done is a single-cycle strobe.
module two_level_lru_writeback_cache_top #(
	parameter int unsigned ADDR_BITS = 32,
	parameter int unsigned L1_SETS = 64,
	parameter int unsigned L1_WAYS = 4,
	parameter int unsigned L2_SETS = 512,
	parameter int unsigned L2_WAYS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        mode,
	input  logic [31:0] address,
	output logic        done,
	output logic        l1_hit,
	output logic        l1_victim_wb,
	output logic        l2_write_hit,
	output logic        l2_read_hit,
	output logic [1:0]  memory_writebacks,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import tlc_pkg::*;

	localparam int unsigned AW = ADDR_BITS;
	localparam int unsigned TW = ADDR_BITS;
	localparam int unsigned S1W = L1_SETS > 1 ? $clog2(L1_SETS) : 1;
	localparam int unsigned S2W = L2_SETS > 1 ? $clog2(L2_SETS) : 1;
	localparam int unsigned R1W = L1_WAYS > 1 ? $clog2(L1_WAYS) : 1;
	localparam int unsigned R2W = L2_WAYS > 1 ? $clog2(L2_WAYS) : 1;
	localparam int unsigned B1MAX = L1_SETS > 1 ? $clog2(L1_SETS + 1) - 1 : 0;
	localparam int unsigned B2MAX = L2_SETS > 1 ? $clog2(L2_SETS + 1) - 1 : 0;
	// A victim rebuilt from an old tag under a new geometry can exceed the address width.
	localparam int unsigned BW = AW + B1MAX;
	localparam int unsigned E1W = TW + 2 + R1W;
	localparam int unsigned E2W = BW + 2 + R2W;
	localparam int unsigned CLRN = (L1_SETS > L2_SETS) ? L1_SETS : L2_SETS;
	localparam int unsigned CW = $clog2(CLRN + 1);
	localparam int unsigned W1C = $clog2(L1_WAYS + 1);
	localparam int unsigned W2C = $clog2(L2_WAYS + 1);

	// Configuration registers.
	logic [3:0] offset_bits_q, l2_set_bits_q, l2_ways_used_q;
	logic [2:0] l1_set_bits_q, l1_ways_used_q;
	logic cfg_wr;
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_bits_q <= 4'd6;
			l1_set_bits_q <= 3'd6;
			l1_ways_used_q <= 3'd4;
			l2_set_bits_q <= 4'd9;
			l2_ways_used_q <= 4'd8;
		end else if (cfg_wr) begin
			unique case (paddr[4:2])
				3'(RegOffsetBits): offset_bits_q <= pwdata[3:0];
				3'(RegL1SetBits):  l1_set_bits_q <= pwdata[2:0];
				3'(RegL1Ways):     l1_ways_used_q <= pwdata[2:0];
				3'(RegL2SetBits):  l2_set_bits_q <= pwdata[3:0];
				3'(RegL2Ways):     l2_ways_used_q <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (paddr[4:2])
			3'(RegOffsetBits): prdata[3:0] = offset_bits_q;
			3'(RegL1SetBits):  prdata[2:0] = l1_set_bits_q;
			3'(RegL1Ways):     prdata[2:0] = l1_ways_used_q;
			3'(RegL2SetBits):  prdata[3:0] = l2_set_bits_q;
			3'(RegL2Ways):     prdata[3:0] = l2_ways_used_q;
			default: ;
		endcase
	end

	// Effective geometry.
	logic [4:0] b1, b2;
	logic [W1C-1:0] u1;
	logic [W2C-1:0] u2;
	always_comb begin
		b1 = (5'(l1_set_bits_q) < 5'(B1MAX)) ? 5'(l1_set_bits_q) : 5'(B1MAX);
		b2 = (5'(l2_set_bits_q) < 5'(B2MAX)) ? 5'(l2_set_bits_q) : 5'(B2MAX);
		if (l1_ways_used_q == '0) u1 = W1C'(1);
		else if (32'(l1_ways_used_q) > L1_WAYS) u1 = W1C'(L1_WAYS);
		else u1 = W1C'(l1_ways_used_q);
		if (l2_ways_used_q == '0) u2 = W2C'(1);
		else if (32'(l2_ways_used_q) > L2_WAYS) u2 = W2C'(L2_WAYS);
		else u2 = W2C'(l2_ways_used_q);
	end

	// Memories.
	logic m1_rd, m1_wr, m2_rd, m2_wr;
	logic [S1W-1:0] m1_ra, m1_wa;
	logic [S2W-1:0] m2_ra, m2_wa;
	logic [L1_WAYS*E1W-1:0] m1_rdata, m1_wdata;
	logic [L2_WAYS*E2W-1:0] m2_rdata, m2_wdata;

	tlc_set_array #(.SETS(L1_SETS), .WAYS(L1_WAYS), .TAG_W(TW)) u_l1 (
		.clk(clk), .rd_en(m1_rd), .rd_addr(m1_ra), .rd_data(m1_rdata),
		.wr_en(m1_wr), .wr_addr(m1_wa), .wr_data(m1_wdata)
	);
	tlc_set_array #(.SETS(L2_SETS), .WAYS(L2_WAYS), .TAG_W(BW)) u_l2 (
		.clk(clk), .rd_en(m2_rd), .rd_addr(m2_ra), .rd_data(m2_rdata),
		.wr_en(m2_wr), .wr_addr(m2_wa), .wr_data(m2_wdata)
	);

	state_t state_q;
	logic [CW-1:0] clr_q;
	logic clearing;
	logic mode_q;
	logic [AW-1:0] block_q;     // block address of the access
	logic [S1W-1:0] s1_q;
	logic [TW-1:0] t1_q;
	logic [BW-1:0] l2blk_q;     // block address for the current L2 pass
	logic l2_is_wr_q;           // current L2 pass is the writeback
	logic [L1_WAYS*E1W-1:0] row1_q;
	logic [R1W-1:0] v1_q;
	logic hit1_q, wb1_q, l2wh_q, l2rh_q;
	logic [1:0] mwb_q;

	assign clearing = clr_q != '0;
	assign busy = clearing | (state_q != ST_IDLE);

	// Field access helpers on a row.
	function automatic logic [E1W-1:0] e1(input logic [L1_WAYS*E1W-1:0] r, input int w);
		e1 = r[w*E1W +: E1W];
	endfunction
	function automatic logic [E2W-1:0] e2(input logic [L2_WAYS*E2W-1:0] r, input int w);
		e2 = r[w*E2W +: E2W];
	endfunction

	// Entry layout: {tag, valid, dirty, rank}.
	// L1 lookup on the row read from memory.
	logic l1_found;
	logic [R1W-1:0] l1_hw, l1_vic;
	logic [L1_WAYS*E1W-1:0] l1_touched;
	always_comb begin
		logic [R1W-1:0] best, way, r, rk, rb;
		logic [E1W-1:0] ent;
		l1_found = 1'b0;
		l1_hw = '0;
		for (int w = L1_WAYS-1; w >= 0; w--) begin
			ent = e1(m1_rdata, w);
			if (W1C'(w) < u1 && ent[R1W+1] && ent[E1W-1 -: TW] == t1_q) begin
				l1_found = 1'b1;
				l1_hw = R1W'(w);
			end
		end
		best = '0;
		for (int w = 1; w < L1_WAYS; w++) begin
			ent = e1(m1_rdata, w);
			rk = ent[R1W-1:0];
			ent = e1(m1_rdata, 32'(best));
			rb = ent[R1W-1:0];
			if (W1C'(w) < u1 && rk < rb)
				best = R1W'(w);
		end
		l1_vic = best;
		way = l1_found ? l1_hw : l1_vic;
		ent = e1(m1_rdata, 32'(way));
		r = ent[R1W-1:0];
		l1_touched = m1_rdata;
		for (int w = 0; w < L1_WAYS; w++) begin
			ent = e1(m1_rdata, w);
			if (ent[R1W-1:0] > r) ent[R1W-1:0] = ent[R1W-1:0] - 1'b1;
			if (R1W'(w) == way) begin
				ent[R1W-1:0] = R1W'(L1_WAYS - 1);
				// A write hit marks the line dirty.
				if (l1_found && mode_q) ent[R1W] = 1'b1;
			end
			l1_touched[w*E1W +: E1W] = ent;
		end
	end

	// L2 access on the row read from memory.
	logic [BW-1:0] t2;
	logic l2_found;
	logic l2_vdirty;
	logic [L2_WAYS*E2W-1:0] l2_new;
	always_comb begin
		logic [R2W-1:0] best, hw, way, r, rk, rb;
		logic [E2W-1:0] ent;
		t2 = BW'(l2blk_q >> b2);
		l2_found = 1'b0;
		hw = '0;
		for (int w = L2_WAYS-1; w >= 0; w--) begin
			ent = e2(m2_rdata, w);
			if (W2C'(w) < u2 && ent[R2W+1] && ent[E2W-1 -: BW] == t2) begin
				l2_found = 1'b1;
				hw = R2W'(w);
			end
		end
		best = '0;
		for (int w = 1; w < L2_WAYS; w++) begin
			ent = e2(m2_rdata, w);
			rk = ent[R2W-1:0];
			ent = e2(m2_rdata, 32'(best));
			rb = ent[R2W-1:0];
			if (W2C'(w) < u2 && rk < rb)
				best = R2W'(w);
		end
		way = l2_found ? hw : best;
		ent = e2(m2_rdata, 32'(best));
		l2_vdirty = ~l2_found & ent[R2W];
		ent = e2(m2_rdata, 32'(way));
		r = ent[R2W-1:0];
		l2_new = m2_rdata;
		for (int w = 0; w < L2_WAYS; w++) begin
			ent = e2(m2_rdata, w);
			if (ent[R2W-1:0] > r) ent[R2W-1:0] = ent[R2W-1:0] - 1'b1;
			if (R2W'(w) == way) begin
				ent[R2W-1:0] = R2W'(L2_WAYS - 1);
				if (l2_found) begin
					if (l2_is_wr_q) ent[R2W] = 1'b1;
				end else begin
					ent[E2W-1 -: BW] = t2;
					ent[R2W+1] = 1'b1;
					ent[R2W] = l2_is_wr_q;
				end
			end
			l2_new[w*E2W +: E2W] = ent;
		end
	end

	// Victim entry as read from L1, and the block address of a dirty victim.
	logic [E1W-1:0] vic_rd;
	logic [BW-1:0] old_blk;
	logic [E1W-1:0] vic_ent;
	assign vic_rd = e1(m1_rdata, 32'(l1_vic));
	assign old_blk = (BW'(vic_rd[E1W-1 -: TW]) << b1) | BW'(s1_q);
	assign vic_ent = e1(row1_q, 32'(v1_q));

	// Filled L1 row.
	logic [L1_WAYS*E1W-1:0] l1_fill;
	always_comb begin
		logic [E1W-1:0] ent;
		l1_fill = row1_q;
		ent = vic_ent;
		ent[E1W-1 -: TW] = t1_q;
		ent[R1W+1] = 1'b1;
		ent[R1W] = mode_q;
		l1_fill[32'(v1_q)*E1W +: E1W] = ent;
	end

	logic [AW-1:0] addr_m, blk_in;
	assign addr_m = AW'({32'd0, address});
	assign blk_in = addr_m >> offset_bits_q;

	// Reset rows for the clearing pass.
	logic [L1_WAYS*E1W-1:0] l1_init;
	logic [L2_WAYS*E2W-1:0] l2_init;
	always_comb begin
		for (int w = 0; w < L1_WAYS; w++) l1_init[w*E1W +: E1W] = E1W'(w);
		for (int w = 0; w < L2_WAYS; w++) l2_init[w*E2W +: E2W] = E2W'(w);
	end
	logic [CW-1:0] clr_idx;
	assign clr_idx = clr_q - 1'b1;

	always_comb begin
		m1_rd = 1'b0; m1_wr = 1'b0; m2_rd = 1'b0; m2_wr = 1'b0;
		m1_ra = s1_q; m1_wa = s1_q; m1_wdata = l1_touched;
		m2_ra = S2W'(l2blk_q & ((BW'(1) << b2) - 1'b1)); m2_wa = m2_ra;
		m2_wdata = l2_new;
		if (clearing) begin
			m1_wr = 32'(clr_idx) < L1_SETS;
			m2_wr = 32'(clr_idx) < L2_SETS;
			m1_wa = S1W'(clr_idx);
			m2_wa = S2W'(clr_idx);
			m1_wdata = l1_init;
			m2_wdata = l2_init;
		end else begin
			unique case (state_q)
				ST_L1RD:  m1_rd = 1'b1;
				ST_L1EV:  m1_wr = l1_found;
				ST_L2RD:  m2_rd = 1'b1;
				ST_L2UPD: m2_wr = 1'b1;
				ST_L1FIL: begin
					m1_wr = 1'b1;
					m1_wdata = l1_fill;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			clr_q <= CW'(CLRN);
		end else if (clearing) begin
			clr_q <= clr_q - 1'b1;
		end else begin
			unique case (state_q)
				ST_IDLE:  if (start) state_q <= ST_L1RD;
				ST_L1RD:  state_q <= ST_L1EV;
				ST_L1EV:  state_q <= l1_found ? ST_DONE : ST_L2RD;
				ST_L2RD:  state_q <= ST_L2UPD;
				ST_L2UPD: state_q <= l2_is_wr_q ? ST_L2RD : ST_L1FIL;
				ST_L1FIL: state_q <= ST_DONE;
				ST_DONE:  state_q <= ST_IDLE;
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				mode_q <= mode;
				block_q <= blk_in;
				s1_q <= S1W'(blk_in & ((AW'(1) << b1) - 1'b1));
				t1_q <= TW'(blk_in >> b1);
				hit1_q <= 1'b0; wb1_q <= 1'b0; l2wh_q <= 1'b0; l2rh_q <= 1'b0;
				mwb_q <= 2'd0;
			end
			ST_L1EV: begin
				row1_q <= l1_touched;
				v1_q <= l1_vic;
				hit1_q <= l1_found;
				wb1_q <= ~l1_found & vic_rd[R1W];
				l2_is_wr_q <= ~l1_found & vic_rd[R1W];
				// The writeback pass goes first and needs the victim's set in L2.
				l2blk_q <= (~l1_found & vic_rd[R1W]) ? old_blk : BW'(block_q);
			end
			ST_L2UPD: begin
				if (l2_vdirty) mwb_q <= mwb_q + 2'd1;
				if (l2_is_wr_q) begin
					l2wh_q <= l2_found;
					l2blk_q <= BW'(block_q);
				end else begin
					l2rh_q <= l2_found;
				end
				l2_is_wr_q <= 1'b0;
			end
			default: ;
		endcase
	end

	assign done = state_q == ST_DONE;
	assign l1_hit = hit1_q;
	assign l1_victim_wb = wb1_q;
	assign l2_write_hit = l2wh_q;
	assign l2_read_hit = l2rh_q;
	assign memory_writebacks = mwb_q;
endmodule

>>> rtl/tlc_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the two-level cache tag model, bound to the top level.
// Depends only on the top level's ports.
module tlc_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input logic l1_hit,
	input logic l1_victim_wb,
	input logic l2_write_hit,
	input logic [1:0] memory_writebacks,
	input logic l2_read_hit,
	input logic pready
);
	a_hit_clean: assert property (@(posedge clk) disable iff (!arst_n)
		done && l1_hit |-> !l1_victim_wb && !l2_read_hit && memory_writebacks == 2'd0)
		else $error("L1 hit reported other events");
	a_wh_needs_wb: assert property (@(posedge clk) disable iff (!arst_n)
		done && l2_write_hit |-> l1_victim_wb)
		else $error("L2 write hit without writeback");
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result without a transaction in flight");
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted transaction did not raise busy");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");
endmodule

bind two_level_lru_writeback_cache_top tlc_checker u_tlc_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
	.l1_hit(l1_hit), .l1_victim_wb(l1_victim_wb), .l2_write_hit(l2_write_hit),
	.memory_writebacks(memory_writebacks), .l2_read_hit(l2_read_hit), .pready(pready)
);
